### design/pngf_pkg.sv
// Shared types, constants and predictor functions for the PNG row filter encoder.
// No dependencies; imported by the top level and the scorer.
`default_nettype none

package pngf_pkg;

   localparam int MAX_ROW_BYTES = 4096;
   localparam int ADDR_W        = $clog2(MAX_ROW_BYTES);
   localparam int LEN_W         = $clog2(MAX_ROW_BYTES + 1);

   localparam int ROW_LEN_W  = 13;
   localparam int BPP_W      = 4;
   localparam int FMODE_W    = 3;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int MAX_BPP    = 8;

   localparam int SHORT_ROW_BYTES = 192;
   localparam int SAMPLE_BYTES    = 64;
   localparam int REM_W           = $clog2(SHORT_ROW_BYTES + 1);
   localparam int SCORE_W         = 16;
   localparam int NUM_FILTERS     = 5;

   // request modes
   localparam logic [1:0] MODE_START = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;

   // response status
   localparam logic [1:0] STAT_NODATA = 2'd0;
   localparam logic [1:0] STAT_DATA   = 2'd1;
   localparam logic [1:0] STAT_REJECT = 2'd2;

   // filter types
   localparam logic [FMODE_W-1:0] FILT_NONE     = 3'd0;
   localparam logic [FMODE_W-1:0] FILT_SUB      = 3'd1;
   localparam logic [FMODE_W-1:0] FILT_UP       = 3'd2;
   localparam logic [FMODE_W-1:0] FILT_AVG      = 3'd3;
   localparam logic [FMODE_W-1:0] FILT_PAETH    = 3'd4;
   localparam logic [FMODE_W-1:0] FILT_ADAPTIVE = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BPP        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FMODE      = 2'd2;

   // one byte with its masked neighbors
   typedef struct packed {
      logic [7:0] x;
      logic [7:0] l;
      logic [7:0] u;
      logic [7:0] ul;
   } pix_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] idx;
   } rd_req_type;

   typedef struct packed {
      logic               done;
      logic [FMODE_W-1:0] choice;
   } score_res_type;

   function automatic logic [7:0] pngf_predict(input logic [FMODE_W-1:0] kind,
                                               input pix_type p);
      logic signed [10:0] da;
      logic signed [10:0] db;
      logic signed [10:0] dc;
      logic [9:0]         pa;
      logic [9:0]         pb;
      logic [9:0]         pc;
      logic [8:0]         sum;
      logic [7:0]         res;
      begin
         // pa = |est - l|, pb = |est - u|, pc = |est - ul|
         da  = $signed({3'b000, p.u}) - $signed({3'b000, p.ul});
         db  = $signed({3'b000, p.l}) - $signed({3'b000, p.ul});
         dc  = da + db;
         pa  = da[10] ? 10'(-da) : 10'(da);
         pb  = db[10] ? 10'(-db) : 10'(db);
         pc  = dc[10] ? 10'(-dc) : 10'(dc);
         sum = {1'b0, p.l} + {1'b0, p.u};
         case (kind)
            FILT_SUB:   res = p.l;
            FILT_UP:    res = p.u;
            FILT_AVG:   res = sum[8:1];
            FILT_PAETH: begin
               if (pa <= pb && pa <= pc) begin
                  res = p.l;
               end else if (pb <= pc) begin
                  res = p.u;
               end else begin
                  res = p.ul;
               end
            end
            default:    res = 8'd0;
         endcase
         return res;
      end
   endfunction

   // magnitude of the residual read as a signed byte
   function automatic logic [7:0] pngf_resid_mag(input logic [7:0] x, input logic [7:0] pred);
      logic [7:0] r;
      begin
         r = x - pred;
         return r[7] ? 8'(~r + 8'd1) : r;
      end
   endfunction

endpackage

`default_nettype wire

### design/png_row_filter_encoder.sv
// PNG row filter encoder, top level: request decode, row buffers, emit path, output queue.
// Depends on pngf_pkg, pngf_ram and pngf_scorer.
// An item's response is registered into the output queue when the item is accepted.
// Start and load items one per cycle while the output queue has room; a read item
// holds input in the fetch state for the row buffer read. A row completing in adaptive
// mode stalls input for the scoring pass over N = row length up to 192 bytes, else 192 sampled bytes.
// Reset (synchronous): registers to defaults, loading phase, no previous row; no clear pass.
`default_nettype none

module png_row_filter_encoder
   import pngf_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_mode,
   input  wire logic [7:0]            req_data_byte,
   // response channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_last,
   output logic [1:0]                 rsp_status,
   // register write port
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int FIFO_DEPTH = 2;
   localparam int CMP_W      = (LEN_W > ROW_LEN_W) ? LEN_W : ROW_LEN_W;

   // READY: row buffer data for the current emit position is valid
   // FETCH: waits for the buffer read after the emit position moved
   // SCORE: adaptive scoring pass owns the read ports
   typedef enum logic [1:0] {ST_READY, ST_FETCH, ST_SCORE} state_type;
   typedef enum logic {PH_LOAD, PH_EMIT} phase_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic [1:0] status;
   } rsp_type;

   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [1:0]         cnt_ff, cnt_in;
   rsp_type            slot0_ff, slot0_in;
   rsp_type            slot1_ff, slot1_in;
   logic [ROW_LEN_W-1:0] row_length_ff, row_length_in;
   logic [BPP_W-1:0]   bpp_ff, bpp_in;
   logic [FMODE_W-1:0] fmode_ff, fmode_in;
   logic               prev_valid_ff, prev_valid_in;
   logic [LEN_W-1:0]   prev_len_ff, prev_len_in;
   logic [LEN_W-1:0]   load_pos_ff, load_pos_in;
   logic [LEN_W-1:0]   emit_pos_ff, emit_pos_in;
   logic [LEN_W-1:0]   emit_len_ff, emit_len_in;
   logic [BPP_W-1:0]   emit_bpp_ff, emit_bpp_in;
   logic [FMODE_W-1:0] chosen_ff, chosen_in;
   logic               bank_sel_ff, bank_sel_in;
   logic               start_ff, start_in;
   logic [ADDR_W-1:0]  rd_idx_ff;
   logic               rd_vld_ff;

   logic               accept;
   logic               pop;
   rsp_type            rsp_new;
   logic               mem_we;
   logic [LEN_W-1:0]   eff_len;
   logic [BPP_W-1:0]   eff_bpp;
   logic [LEN_W-1:0]   load_next;
   logic               row_last;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  rd_addr_left;
   logic [7:0]         b0_a, b0_b, b1_a, b1_b;
   logic               l_ok, u_ok, ul_ok;
   pix_type            pix;
   logic [7:0]         resid;
   rd_req_type         score_rd;
   score_res_type      score_res;

   assign accept    = req_valid && req_ready;
   assign pop       = (cnt_ff != 2'd0) && rsp_ready;
   assign req_ready = (state_ff == ST_READY) && (32'(cnt_ff) < FIFO_DEPTH);

   // live register values, saturated into range
   always_comb begin
      if (row_length_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (CMP_W'(row_length_ff) > CMP_W'(MAX_ROW_BYTES)) begin
         eff_len = LEN_W'(MAX_ROW_BYTES);
      end else begin
         eff_len = LEN_W'(row_length_ff);
      end
      if (bpp_ff == '0) begin
         eff_bpp = BPP_W'(1);
      end else if (bpp_ff > BPP_W'(MAX_BPP)) begin
         eff_bpp = BPP_W'(MAX_BPP);
      end else begin
         eff_bpp = bpp_ff;
      end
   end

   assign load_next = load_pos_ff + LEN_W'(1);
   assign row_last  = (emit_pos_ff != '0) && (emit_pos_ff >= emit_len_ff);

   // Both banks see the same addresses: byte i and its left neighbor.
   // bank_sel picks which bank is the current row; the other holds the previous row.
   assign rd_addr      = (state_ff == ST_SCORE) ? score_rd.idx
                                                : ADDR_W'(emit_pos_ff - LEN_W'(1));
   assign rd_addr_left = rd_addr - ADDR_W'(emit_bpp_ff);

   pngf_ram #(.WIDTH(8), .DEPTH(MAX_ROW_BYTES)) u_bank0 (
      .clock     (clock),
      .wr_en     (mem_we && !bank_sel_ff),
      .wr_addr   (load_pos_ff[ADDR_W-1:0]),
      .wr_data   (req_data_byte),
      .rd_addr_a (rd_addr),
      .rd_addr_b (rd_addr_left),
      .rd_data_a (b0_a),
      .rd_data_b (b0_b)
   );

   pngf_ram #(.WIDTH(8), .DEPTH(MAX_ROW_BYTES)) u_bank1 (
      .clock     (clock),
      .wr_en     (mem_we && bank_sel_ff),
      .wr_addr   (load_pos_ff[ADDR_W-1:0]),
      .wr_data   (req_data_byte),
      .rd_addr_a (rd_addr),
      .rd_addr_b (rd_addr_left),
      .rd_data_a (b1_a),
      .rd_data_b (b1_b)
   );

   // Neighbor masks from the index that produced this cycle's read data.
   // Left bytes before the first pixel, and above bytes beyond the previous
   // row (or with no previous row), read as zero.
   assign l_ok  = LEN_W'(rd_idx_ff) >= LEN_W'(emit_bpp_ff);
   assign u_ok  = prev_valid_ff && (LEN_W'(rd_idx_ff) < prev_len_ff);
   assign ul_ok = l_ok && prev_valid_ff
                  && (LEN_W'(rd_idx_ff - ADDR_W'(emit_bpp_ff)) < prev_len_ff);

   assign pix.x  = bank_sel_ff ? b1_a : b0_a;
   assign pix.l  = l_ok  ? (bank_sel_ff ? b1_b : b0_b) : 8'd0;
   assign pix.u  = u_ok  ? (bank_sel_ff ? b0_a : b1_a) : 8'd0;
   assign pix.ul = ul_ok ? (bank_sel_ff ? b0_b : b1_b) : 8'd0;

   assign resid = pix.x - pngf_predict(chosen_ff, pix);

   pngf_scorer u_scorer (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .emit_len  (emit_len_ff),
      .pix       (pix),
      .pix_valid (rd_vld_ff),
      .rd_req    (score_rd),
      .res       (score_res)
   );

   // request decode and control
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      row_length_in = row_length_ff;
      bpp_in        = bpp_ff;
      fmode_in      = fmode_ff;
      prev_valid_in = prev_valid_ff;
      prev_len_in   = prev_len_ff;
      load_pos_in   = load_pos_ff;
      emit_pos_in   = emit_pos_ff;
      emit_len_in   = emit_len_ff;
      emit_bpp_in   = emit_bpp_ff;
      chosen_in     = chosen_ff;
      bank_sel_in   = bank_sel_ff;
      start_in      = 1'b0;
      mem_we        = 1'b0;
      rsp_new.out_byte = 8'd0;
      rsp_new.last     = 1'b0;
      rsp_new.status   = STAT_REJECT;

      if (csr_we) begin
         unique case (csr_index)
            REG_ROW_LENGTH: row_length_in = ROW_LEN_W'(csr_wdata);
            REG_BPP:        bpp_in        = csr_wdata[BPP_W-1:0];
            REG_FMODE:      fmode_in      = csr_wdata[FMODE_W-1:0];
            default:        ;
         endcase
      end

      unique case (state_ff)
         ST_FETCH: state_in = ST_READY;
         ST_SCORE: begin
            if (score_res.done) begin
               chosen_in = score_res.choice;
               state_in  = ST_READY;
            end
         end
         default: ;
      endcase

      if (accept) begin
         case (req_mode)
            MODE_START: begin
               // drops any row in progress and forgets the previous row
               prev_valid_in  = 1'b0;
               prev_len_in    = '0;
               load_pos_in    = '0;
               emit_pos_in    = '0;
               phase_in       = PH_LOAD;
               rsp_new.status = STAT_NODATA;
            end
            MODE_LOAD: begin
               if (phase_ff == PH_LOAD) begin
                  mem_we         = 1'b1;
                  load_pos_in    = load_next;
                  rsp_new.status = STAT_NODATA;
                  if (load_next >= eff_len) begin
                     emit_len_in = load_next;
                     emit_bpp_in = eff_bpp;
                     emit_pos_in = '0;
                     phase_in    = PH_EMIT;
                     if (fmode_ff >= FILT_ADAPTIVE) begin
                        state_in = ST_SCORE;
                        start_in = 1'b1;
                     end else begin
                        chosen_in = fmode_ff;
                     end
                  end
               end
            end
            MODE_READ: begin
               if (phase_ff == PH_EMIT) begin
                  rsp_new.status   = STAT_DATA;
                  rsp_new.out_byte = (emit_pos_ff == '0) ? 8'(chosen_ff) : resid;
                  rsp_new.last     = row_last;
                  emit_pos_in      = emit_pos_ff + LEN_W'(1);
                  state_in         = ST_FETCH;
                  if (row_last) begin
                     // this row becomes the previous row: swap bank roles
                     prev_valid_in = 1'b1;
                     prev_len_in   = emit_len_ff;
                     bank_sel_in   = !bank_sel_ff;
                     load_pos_in   = '0;
                     emit_pos_in   = '0;
                     phase_in      = PH_LOAD;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // two-entry output queue; slot0 is the head
   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff + {1'b0, accept} - {1'b0, pop};
      if (accept && ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop))) begin
         slot0_in = rsp_new;
      end
      if (accept && (cnt_ff == 2'd1) && !pop) begin
         slot1_in = rsp_new;
      end
      if (pop && (cnt_ff == 2'd2)) begin
         slot0_in = slot1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_READY;
         phase_ff      <= PH_LOAD;
         cnt_ff        <= '0;
         row_length_ff <= ROW_LEN_W'(MAX_ROW_BYTES);
         bpp_ff        <= BPP_W'(1);
         fmode_ff      <= FILT_ADAPTIVE;
         prev_valid_ff <= 1'b0;
         prev_len_ff   <= '0;
         load_pos_ff   <= '0;
         emit_pos_ff   <= '0;
         emit_len_ff   <= '0;
         emit_bpp_ff   <= '0;
         chosen_ff     <= FILT_NONE;
         bank_sel_ff   <= 1'b0;
         start_ff      <= 1'b0;
         rd_vld_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         row_length_ff <= row_length_in;
         bpp_ff        <= bpp_in;
         fmode_ff      <= fmode_in;
         prev_valid_ff <= prev_valid_in;
         prev_len_ff   <= prev_len_in;
         load_pos_ff   <= load_pos_in;
         emit_pos_ff   <= emit_pos_in;
         emit_len_ff   <= emit_len_in;
         emit_bpp_ff   <= emit_bpp_in;
         chosen_ff     <= chosen_in;
         bank_sel_ff   <= bank_sel_in;
         start_ff      <= start_in;
         rd_vld_ff     <= (state_ff == ST_SCORE) && score_rd.valid;
      end
      slot0_ff  <= slot0_in;
      slot1_ff  <= slot1_in;
      rd_idx_ff <= rd_addr;
   end

   assign rsp_valid    = (cnt_ff != 2'd0);
   assign rsp_out_byte = slot0_ff.out_byte;
   assign rsp_last     = slot0_ff.last;
   assign rsp_status   = slot0_ff.status;

   // queue never overfills
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= FIFO_DEPTH)
      else $error("output queue overflow");

   // an emitted data byte uses buffer data read for its own position
   a_read_aligned: assert property (@(posedge clock) disable iff (reset)
      accept && (req_mode == MODE_READ) && (phase_ff == PH_EMIT) && (emit_pos_ff != '0)
      |-> rd_idx_ff == ADDR_W'(emit_pos_ff - LEN_W'(1)))
      else $error("emit read data not aligned with emit position");

   // scorer finishes only while the top waits for it
   a_score_owner: assert property (@(posedge clock) disable iff (reset)
      score_res.done |-> state_ff == ST_SCORE)
      else $error("scorer done outside scoring pass");

   // emit position stays within the latched row length
   a_emit_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_EMIT |-> emit_pos_ff <= emit_len_ff)
      else $error("emit position beyond row length");

   // a scoring pass starts only with input held off
   a_score_start: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> (state_ff == ST_SCORE) && !req_ready)
      else $error("scoring started while accepting items");

endmodule

`default_nettype wire

### design/pngf_ram.sv
// Generic synchronous RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module pngf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

### design/pngf_scorer.sv
// Adaptive filter scorer: walks all or sampled bytes of a row, sums residual magnitudes.
// Depends on pngf_pkg; reads the row buffers through the top level.
`default_nettype none

module pngf_scorer
   import pngf_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [LEN_W-1:0] emit_len,
   input  wire pix_type          pix,
   input  wire logic             pix_valid,
   output rd_req_type            rd_req,
   output score_res_type         res
);

   typedef enum logic [1:0] {SC_IDLE, SC_ISSUE, SC_DRAIN} sc_state_type;
   typedef enum logic [1:0] {SEG_HEAD, SEG_MID, SEG_TAIL} seg_type;

   sc_state_type      state_ff, state_in;
   seg_type           seg_ff, seg_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic              mag_vld_ff;
   logic [7:0]        mag_ff   [NUM_FILTERS];
   logic [SCORE_W-1:0] score_ff [NUM_FILTERS];

   logic              is_short;
   logic [ADDR_W-1:0] mid_start;
   logic [ADDR_W-1:0] tail_start;
   logic              done;
   logic [FMODE_W-1:0] win;

   assign is_short   = 32'(emit_len) <= SHORT_ROW_BYTES;
   assign mid_start  = ADDR_W'((32'(emit_len) - SAMPLE_BYTES) >> 1);
   assign tail_start = ADDR_W'(32'(emit_len) - SAMPLE_BYTES);
   assign done       = (state_ff == SC_DRAIN) && !pix_valid && !mag_vld_ff;

   always_comb begin
      state_in = state_ff;
      seg_in   = seg_ff;
      idx_in   = idx_ff;
      rem_in   = rem_ff;
      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               state_in = SC_ISSUE;
               idx_in   = '0;
               seg_in   = is_short ? SEG_TAIL : SEG_HEAD;
               rem_in   = is_short ? REM_W'(emit_len) : REM_W'(SAMPLE_BYTES);
            end
         end
         SC_ISSUE: begin
            if (rem_ff == REM_W'(1)) begin
               unique case (seg_ff)
                  SEG_HEAD: begin
                     seg_in = SEG_MID;
                     idx_in = mid_start;
                     rem_in = REM_W'(SAMPLE_BYTES);
                  end
                  SEG_MID: begin
                     seg_in = SEG_TAIL;
                     idx_in = tail_start;
                     rem_in = REM_W'(SAMPLE_BYTES);
                  end
                  default: state_in = SC_DRAIN;
               endcase
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
               rem_in = rem_ff - REM_W'(1);
            end
         end
         SC_DRAIN: begin
            if (done) begin
               state_in = SC_IDLE;
            end
         end
         default: state_in = SC_IDLE;
      endcase
   end

   // lowest score wins, ties to the lower filter
   always_comb begin
      win = FILT_NONE;
      for (int k = 1; k < NUM_FILTERS; k++) begin
         if (score_ff[k] < score_ff[win]) begin
            win = FMODE_W'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SC_IDLE;
         mag_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         mag_vld_ff <= pix_valid;
      end
      seg_ff <= seg_in;
      idx_ff <= idx_in;
      rem_ff <= rem_in;
      if (pix_valid) begin
         for (int k = 0; k < NUM_FILTERS; k++) begin
            mag_ff[k] <= pngf_resid_mag(pix.x, pngf_predict(FMODE_W'(k), pix));
         end
      end
      for (int k = 0; k < NUM_FILTERS; k++) begin
         if (start) begin
            score_ff[k] <= '0;
         end else if (mag_vld_ff) begin
            score_ff[k] <= score_ff[k] + SCORE_W'(mag_ff[k]);
         end
      end
   end

   assign rd_req.valid = (state_ff == SC_ISSUE);
   assign rd_req.idx   = idx_ff;
   assign res.done     = done;
   assign res.choice   = win;

endmodule

`default_nettype wire
